FILE: rtl/core/modular_exponentiation_core_assert.svh
// Assertion macros for the checker of this block.
`ifndef MODULAR_EXPONENTIATION_CORE_ASSERT_SVH
`define MODULAR_EXPONENTIATION_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MEXP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("modexp assertion failed");

// Next-cycle implication, disabled during reset.
`define MEXP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("modexp assertion failed");

`endif

FILE: rtl/core/mexp_pkg.sv
package mexp_pkg;

  localparam int WORD_WIDTH_DEF  = 32;
  localparam int FIELD_WIDTH     = 32;
  localparam int CFG_INDEX_WIDTH = 1;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_EXPONENT = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS  = 1'b1;

  // Control from the sequencer to a multiplier lane.
  typedef struct packed {
    logic load;
    logic step;
    logic mult_bit;
  } lane_ctl_t;

endpackage

FILE: rtl/core/mexp_reduce.sv
// Bit-serial remainder: shifts x in MSB first, one bit per step.
module mexp_reduce #(
  parameter int WORD_WIDTH = mexp_pkg::WORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  load,
  input  logic                  step,
  input  logic [WORD_WIDTH-1:0] x,
  input  logic [WORD_WIDTH-1:0] m,
  output logic [WORD_WIDTH-1:0] rem
);

  logic [WORD_WIDTH-1:0] xsh;
  logic [WORD_WIDTH-1:0] r;
  logic [WORD_WIDTH:0]   r2;
  logic [WORD_WIDTH+1:0] diff;

  assign r2   = {r, xsh[WORD_WIDTH-1]};
  assign diff = {1'b0, r2} - {2'b00, m};
  assign rem  = r;

  always_ff @(posedge clk) begin
    if (load) begin
      xsh <= x;
      r   <= '0;
    end else if (step) begin
      xsh <= {xsh[WORD_WIDTH-2:0], 1'b0};
      // r < m keeps r2 < 2m, so one conditional subtract suffices
      r   <= diff[WORD_WIDTH+1] ? r2[WORD_WIDTH-1:0] : diff[WORD_WIDTH-1:0];
    end
  end

endmodule

FILE: rtl/core/mexp_lane.sv
// Shift-and-add modular multiply lane: acc += a when the multiplier bit
// is set, a doubles mod m every step. Multiplier bits arrive LSB first.
module mexp_lane #(
  parameter int WORD_WIDTH = mexp_pkg::WORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  mexp_pkg::lane_ctl_t   ctl,
  input  logic [WORD_WIDTH-1:0] a_init,
  input  logic [WORD_WIDTH-1:0] m,
  output logic [WORD_WIDTH-1:0] product
);

  logic [WORD_WIDTH-1:0] acc;
  logic [WORD_WIDTH-1:0] a;

  function automatic logic [WORD_WIDTH-1:0] add_mod(
    input logic [WORD_WIDTH-1:0] p,
    input logic [WORD_WIDTH-1:0] q,
    input logic [WORD_WIDTH-1:0] md
  );
    logic [WORD_WIDTH:0]   s;
    logic [WORD_WIDTH+1:0] d;
    s = {1'b0, p} + {1'b0, q};
    d = {1'b0, s} - {2'b00, md};
    return d[WORD_WIDTH+1] ? s[WORD_WIDTH-1:0] : d[WORD_WIDTH-1:0];
  endfunction

  assign product = acc;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc <= '0;
      a   <= a_init;
    end else if (ctl.step) begin
      if (ctl.mult_bit) begin
        acc <= add_mod(acc, a, m);
      end
      a <= add_mod(a, a, m);
    end
  end

endmodule

FILE: rtl/core/modular_exponentiation_core.sv
// Modular exponentiation core: power_result = base ^ exponent mod modulus.
// Configuration: write exponent (index 0) and modulus (index 1) through
// cfg_write / cfg_index / cfg_data while the core is idle; both reset to 0.
// Input: a base beat is taken when base_valid is high and base_stall low.
// The core holds one item at a time; base_stall is high while it works.
// Output: one beat per base on power_result / modulus_error, taken when
// result_valid is high and result_stall low. The result sits in an output
// register, so a new base is accepted while an old result is still stalled.
// A zero modulus or a zero exponent skips the computation; otherwise the core
// reduces the base, then runs one multiply pass per exponent bit up to the
// highest set bit. A new base is taken only after the previous item has left
// the core's last state.
// The work is done by the bit-serial remainder and by the two shift-and-add
// multiply lanes, which run side by side for each exponent bit.
// A zero modulus gives modulus_error = 1 with power_result = 0.
// A stalled result holds until taken; a finished item waits in its last
// state until the output register is free. Reset clears all control state
// and both configuration registers.
module modular_exponentiation_core #(
  parameter int WORD_WIDTH = mexp_pkg::WORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [mexp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [mexp_pkg::FIELD_WIDTH-1:0]     cfg_data,
  input  logic                                 base_valid,
  output logic                                 base_stall,
  input  logic [mexp_pkg::FIELD_WIDTH-1:0]     base,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [mexp_pkg::FIELD_WIDTH-1:0]     power_result,
  output logic                                 modulus_error
);

  localparam int FW    = mexp_pkg::FIELD_WIDTH;
  localparam int CNT_W = $clog2(WORD_WIDTH + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_INIT   = 3'd2;
  localparam logic [2:0] ST_LOAD   = 3'd3;
  localparam logic [2:0] ST_MUL    = 3'd4;
  localparam logic [2:0] ST_UPDATE = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [FW-1:0] exponent;
  logic [FW-1:0] modulus;

  logic [2:0]            state;
  logic [CNT_W-1:0]      cnt;
  logic [WORD_WIDTH-1:0] acc;
  logic [WORD_WIDTH-1:0] sq;
  logic [WORD_WIDTH-1:0] e_work;
  logic [WORD_WIDTH-1:0] bsh;
  logic                  err;

  logic [WORD_WIDTH+FW-1:0] mod_ext;
  logic [WORD_WIDTH+FW-1:0] exp_ext;
  logic [WORD_WIDTH+FW-1:0] base_ext;
  logic [WORD_WIDTH+FW-1:0] acc_ext;
  logic [WORD_WIDTH-1:0]    mod_w;
  logic [WORD_WIDTH-1:0]    exp_w;
  logic [WORD_WIDTH-1:0]    base_w;
  logic [WORD_WIDTH-1:0]    one_mod;
  logic [WORD_WIDTH-1:0]    rem;
  logic [WORD_WIDTH-1:0]    mul_prod;
  logic [WORD_WIDTH-1:0]    sq_prod;
  logic [WORD_WIDTH-1:0]    e_shift;

  logic                base_take;
  logic                out_free;
  logic                last_step;
  mexp_pkg::lane_ctl_t lane_ctl;

  // operands live in the low WORD_WIDTH bits
  assign mod_ext  = {{WORD_WIDTH{1'b0}}, modulus};
  assign exp_ext  = {{WORD_WIDTH{1'b0}}, exponent};
  assign base_ext = {{WORD_WIDTH{1'b0}}, base};
  assign acc_ext  = {{FW{1'b0}}, acc};
  assign mod_w    = mod_ext[WORD_WIDTH-1:0];
  assign exp_w    = exp_ext[WORD_WIDTH-1:0];
  assign base_w   = base_ext[WORD_WIDTH-1:0];
  assign one_mod  = (mod_w == WORD_WIDTH'(1)) ? '0 : WORD_WIDTH'(1);
  assign e_shift  = {1'b0, e_work[WORD_WIDTH-1:1]};

  assign base_stall = (state != ST_IDLE);
  assign base_take  = base_valid && !base_stall;
  assign out_free   = !result_valid || !result_stall;
  assign last_step  = (cnt == CNT_W'(1));

  assign lane_ctl.load     = (state == ST_LOAD);
  assign lane_ctl.step     = (state == ST_MUL);
  assign lane_ctl.mult_bit = bsh[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= '0;
      modulus  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mexp_pkg::REG_EXPONENT: exponent <= cfg_data;
        mexp_pkg::REG_MODULUS:  modulus  <= cfg_data;
        default: ;
      endcase
    end
  end

  mexp_reduce #(.WORD_WIDTH(WORD_WIDTH)) u_reduce (
    .clk  (clk),
    .load (base_take),
    .step (state == ST_REDUCE),
    .x    (base_w),
    .m    (mod_w),
    .rem  (rem)
  );

  mexp_lane #(.WORD_WIDTH(WORD_WIDTH)) u_lane_mul (
    .clk     (clk),
    .ctl     (lane_ctl),
    .a_init  (acc),
    .m       (mod_w),
    .product (mul_prod)
  );

  mexp_lane #(.WORD_WIDTH(WORD_WIDTH)) u_lane_sq (
    .clk     (clk),
    .ctl     (lane_ctl),
    .a_init  (sq),
    .m       (mod_w),
    .product (sq_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (base_take) begin
            if (mod_w == '0) begin
              acc   <= '0;
              err   <= 1'b1;
              state <= ST_DONE;
            end else if (exp_w == '0) begin
              acc   <= WORD_WIDTH'(1);
              err   <= 1'b0;
              state <= ST_DONE;
            end else begin
              err    <= 1'b0;
              e_work <= exp_w;
              cnt    <= CNT_W'(WORD_WIDTH);
              state  <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          cnt <= cnt - CNT_W'(1);
          if (last_step) begin
            state <= ST_INIT;
          end
        end
        ST_INIT: begin
          sq    <= rem;
          acc   <= one_mod;
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          bsh   <= sq;
          cnt   <= CNT_W'(WORD_WIDTH);
          state <= ST_MUL;
        end
        ST_MUL: begin
          bsh <= {1'b0, bsh[WORD_WIDTH-1:1]};
          cnt <= cnt - CNT_W'(1);
          if (last_step) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (e_work[0]) begin
            acc <= mul_prod;
          end
          sq     <= sq_prod;
          e_work <= e_shift;
          state  <= (e_shift == '0) ? ST_DONE : ST_LOAD;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      power_result  <= acc_ext[FW-1:0];
      modulus_error <= err;
    end
  end

endmodule

FILE: rtl/core/mexp_checker.sv
`include "modular_exponentiation_core_assert.svh"

module mexp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             base_valid,
  input logic                             base_stall,
  input logic                             result_valid,
  input logic                             result_stall,
  input logic [mexp_pkg::FIELD_WIDTH-1:0] power_result,
  input logic                             modulus_error
);

  // a flagged result carries a zero value
  `MEXP_ASSERT_NOW(a_err_zero, clk, rst, result_valid && modulus_error, power_result == '0)

  // one item in flight: the core is busy right after taking a base
  `MEXP_ASSERT_NEXT(a_busy_after_take, clk, rst, base_valid && !base_stall, base_stall)

  // no result can appear the cycle after a base is taken
  `MEXP_ASSERT_NEXT(a_no_instant_result, clk, rst, base_valid && !base_stall,
    !$rose(result_valid))

  // a stalled result stays offered
  `MEXP_ASSERT_NEXT(a_result_held, clk, rst, result_valid && result_stall, result_valid)

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
  .clk           (clk),
  .rst           (rst),
  .base_valid    (base_valid),
  .base_stall    (base_stall),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .power_result  (power_result),
  .modulus_error (modulus_error)
);

FILE: tb/sv/tb_modular_exponentiation_core.sv
`timescale 1ns / 100ps

module tb_modular_exponentiation_core;

  localparam int W = mexp_pkg::FIELD_WIDTH;
  localparam int CIW = mexp_pkg::CFG_INDEX_WIDTH;
  localparam int ITEM_TARGET = 540;

  typedef struct packed {
    logic [W-1:0] power;
    logic         err;
  } power_beat_t;

  // Holds the register copy and the queue of powers still owed by the core.
  class power_ledger;
    logic [W-1:0] exponent;
    logic [W-1:0] modulus;
    power_beat_t  expected_powers[$];
    int           failures;

    function new();
      exponent = '0;
      modulus  = '0;
      failures = 0;
    endfunction

    // Right-to-left square-and-multiply; 64-bit products are exact for W = 32.
    function power_beat_t mod_power(logic [W-1:0] b);
      power_beat_t  r;
      bit [63:0]    acc;
      bit [63:0]    sq;
      bit [63:0]    m;
      logic [W-1:0] bits_left;
      r.err   = (modulus == '0);
      r.power = '0;
      if (modulus == '0) return r;
      if (exponent == '0) begin
        r.power = 1;  // not reduced, so a modulus of one still gives 1
        return r;
      end
      m         = 64'(modulus);
      sq        = b % m;
      acc       = 64'd1 % m;
      bits_left = exponent;
      while (bits_left != '0) begin
        if (bits_left[0]) acc = (acc * sq) % m;
        sq        = (sq * sq) % m;
        bits_left = bits_left >> 1;
      end
      r.power = acc[W-1:0];
      return r;
    endfunction

    function void note_base(logic [W-1:0] b);
      expected_powers.push_back(mod_power(b));
    endfunction

    function void check_result(logic [W-1:0] p, logic e);
      power_beat_t want;
      if (expected_powers.size() == 0) begin
        $display("%0t: result with nothing expected: power_result %h modulus_error %b",
                 $time, p, e);
        failures++;
        return;
      end
      want = expected_powers.pop_front();
      if (p !== want.power) begin
        $display("%0t: power_result expected %h actual %h", $time, want.power, p);
        failures++;
      end
      if (e !== want.err) begin
        $display("%0t: modulus_error expected %b actual %b", $time, want.err, e);
        failures++;
      end
    endfunction
  endclass

  logic           clk;
  logic           rst = 1'b1;
  logic           cfg_write = 1'b0;
  logic [CIW-1:0] cfg_index = '0;
  logic [W-1:0]   cfg_data = '0;
  logic           base_valid = 1'b0;
  logic           base_stall;
  logic [W-1:0]   base = '0;
  logic           result_valid;
  logic           result_stall = 1'b0;
  logic [W-1:0]   power_result;
  logic           modulus_error;

  power_ledger ledger = new();
  int          items_sent = 0;
  int          hold_cycles = 0;
  bit          calm_source = 1'b0;
  bit          calm_sink = 1'b0;

  modular_exponentiation_core uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .base_valid   (base_valid),
    .base_stall   (base_stall),
    .base         (base),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .power_result (power_result),
    .modulus_error(modulus_error)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Caller lowers cfg_write after its last write.
  task automatic write_reg(logic [CIW-1:0] idx, logic [W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      mexp_pkg::REG_EXPONENT: ledger.exponent = val;
      mexp_pkg::REG_MODULUS:  ledger.modulus  = val;
    endcase
  endtask

  task automatic configure(logic [W-1:0] e, logic [W-1:0] m, bit modulus_first);
    if (modulus_first) begin
      write_reg(mexp_pkg::REG_MODULUS, m);
      write_reg(mexp_pkg::REG_EXPONENT, e);
    end else begin
      write_reg(mexp_pkg::REG_EXPONENT, e);
      write_reg(mexp_pkg::REG_MODULUS, m);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic send_base(logic [W-1:0] value);
    int gap;
    gap = calm_source ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      base_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    base_valid <= 1'b1;
    base       <= value;
    do @(posedge clk); while (base_stall);
    ledger.note_base(value);
    items_sent++;
  endtask

  // Lower valid and wait until every owed power has come back.
  task automatic drain();
    base_valid <= 1'b0;
    while (ledger.expected_powers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [W-1:0] draw_exponent();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom_range(1, 15);
      4, 5:    return $urandom_range(16, 65535);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [W-1:0] draw_modulus();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return 1;
      2:       return $urandom_range(2, 255);
      3:       return $urandom_range(256, 65535);
      4:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [W-1:0] draw_base(logic [W-1:0] m);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return m - 1;
      3:       return m;
      4:       return m + $urandom_range(1, 3);
      5, 6:    return (m == '0) ? $urandom : $urandom % m;
      default: return $urandom;
    endcase
  endfunction

  // Result side: random stalls, mostly while a beat is waiting.
  initial begin : result_sink
    int pause;
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        pause       = hold_cycles;
        hold_cycles = 0;
        result_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end else begin
        pause = calm_sink ? 0 : $urandom_range(0, 10);
        if (pause > 0) begin
          result_stall <= 1'b1;
          do @(posedge clk); while (!result_valid);
          repeat (pause) @(posedge clk);
        end
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!(result_valid && !result_stall));
      ledger.check_result(power_result, modulus_error);
    end
  end

  initial begin : stimulus
    int           phase_len;
    logic [W-1:0] e;
    logic [W-1:0] m;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // registers still at reset: zero modulus
    send_base('0);
    send_base('1);
    drain();

    // zero exponent with modulus one still gives 1
    configure('0, 1, 1'b0);
    send_base(5);
    send_base('1);
    drain();

    configure('1, '0, 1'b1);
    send_base(7);
    drain();

    configure('1, '1, 1'b0);
    send_base('0);
    send_base(1);
    send_base('1);
    send_base(32'hFFFF_FFFE);
    send_base(32'h8000_0000);
    drain();

    // largest 32-bit prime; bases at and above the modulus
    configure(32'd65537, 32'hFFFF_FFFB, 1'b1);
    send_base(2);
    send_base(32'hFFFF_FFFB);
    send_base(32'hFFFF_FFFC);
    send_base(32'd12345);
    drain();

    configure(3, 1, 1'b0);
    send_base('1);
    drain();

    configure(1, 32'h8000_0000, 1'b0);
    send_base(32'hDEAD_BEEF);
    drain();

    configure(32'h8000_0000, 32'h000F_4243, 1'b1);
    send_base($urandom);
    drain();

    // long result hold-off with a steady sender so the core backs up
    configure(3, $urandom | 32'h1, 1'b0);
    calm_source = 1'b1;
    hold_cycles = 600;
    repeat (12) send_base($urandom);
    drain();

    while (items_sent < ITEM_TARGET) begin
      phase_len   = $urandom_range(8, 30);
      calm_source = ($urandom_range(0, 3) == 0);
      calm_sink   = ($urandom_range(0, 3) == 0);
      e = draw_exponent();
      m = draw_modulus();
      configure(e, m, $urandom_range(0, 1));
      repeat (phase_len) send_base(draw_base(m));
      drain();
    end

    repeat (30) @(posedge clk);
    if (ledger.failures == 0 && ledger.expected_powers.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
